@@ rtl/bqdec_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bqdec_pkg: shared types and constants of the biquad decimator
// Field widths, fixed-point format, register codes and the command and
// status groups between the sequencer and the datapath.
// ============================================================================
package bqdec_pkg;

  // Stream fields
  localparam int SAMPLE_W  = 24;
  localparam int CHAN_W    = 8;
  localparam int TS_W      = 48;
  localparam int TDATA_W   = SAMPLE_W + CHAN_W + TS_W;
  localparam int CHAN_LSB  = SAMPLE_W;
  localparam int TS_LSB    = SAMPLE_W + CHAN_W;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int COEF_W    = 32;
  localparam int CNT_W     = 16;

  // Fixed-point format
  localparam int MAX_CHANNELS   = 256;
  localparam int ADDR_W         = $clog2(MAX_CHANNELS);
  localparam int COEF_FRAC_BITS = 30;
  localparam int HISTORY_WIDTH  = 48;
  localparam int HIST_FRAC_BITS = HISTORY_WIDTH - 32;
  localparam int OUT_SHIFT      = COEF_FRAC_BITS + HIST_FRAC_BITS;

  // Datapath widths: w + 2*h1 + h2 needs three guard bits, the running w
  // (input plus two feedback terms) needs four.
  localparam int SUM_W   = HISTORY_WIDTH + 3;
  localparam int W_ACC_W = HISTORY_WIDTH + 4;
  localparam int MAG_W   = SUM_W;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = MUL_W + MAG_W;
  localparam int YR_W    = PROD_W - OUT_SHIFT;

  // History saturation bounds at the width of the running w
  localparam logic signed [W_ACC_W-1:0] W_HMAX =
    {{(W_ACC_W-HISTORY_WIDTH+1){1'b0}}, {(HISTORY_WIDTH-1){1'b1}}};
  localparam logic signed [W_ACC_W-1:0] W_HMIN =
    {{(W_ACC_W-HISTORY_WIDTH+1){1'b1}}, {(HISTORY_WIDTH-1){1'b0}}};

  // Register reset values
  localparam logic [CNT_W-1:0]  DECIM_RST = 16'd1;
  localparam logic [CNT_W-1:0]  BLOCK_RST = 16'd10;
  localparam logic [COEF_W-1:0] B0_RST    = COEF_W'(1) << COEF_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIM = 3'd0,
    REG_BLOCK = 3'd1,
    REG_B0    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAG,
    ST_A1_LO,
    ST_A1_HI,
    ST_A2_LO,
    ST_A2_HI,
    ST_A2_ACC,
    ST_W_FIN,
    ST_SUM,
    ST_B_MAG,
    ST_B_LO,
    ST_B_HI,
    ST_B_ACC,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_A1_LO,
    MUL_A1_HI,
    MUL_A2_LO,
    MUL_A2_HI,
    MUL_B_LO,
    MUL_B_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_A,
    ACC_LOAD_B,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    W_HOLD,
    W_APPLY1,
    W_APPLY2
  } w_op_t;

  typedef struct packed {
    logic     capture;
    logic     fetch;
    logic     mag_a;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    w_op_t    w_op;
    logic     sum_en;
    logic     mag_b;
    logic     hist_wr;
    logic     out_load;
    logic     out_block_last;
  } dp_cmd_t;

  typedef struct packed {
    logic fend;
  } dp_stat_t;

endpackage

@@ rtl/bqdec_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bqdec_datapath: biquad arithmetic, history store and output register
// One shared 32x32 multiplier, a product accumulator, the running w, the
// per-channel history memory and the result register.
// ============================================================================
module bqdec_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [bqdec_pkg::TDATA_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  input  logic                            cfg_valid,
  input  logic [bqdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bqdec_pkg::CFG_W-1:0]     cfg_data,
  input  bqdec_pkg::dp_cmd_t              cmd,
  output bqdec_pkg::dp_stat_t             stat,
  output logic [bqdec_pkg::TDATA_W-1:0]   out_tdata,
  output logic                            out_tlast,
  output logic [0:0]                      out_tuser
);
  import bqdec_pkg::*;

  localparam logic [PROD_W-1:0] RND_A = PROD_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND_B = PROD_W'(1) << (OUT_SHIFT - 1);
  localparam logic [YR_W-1:0]   Y_POS_LIM = {{(YR_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic [YR_W-1:0]   Y_NEG_LIM = YR_W'(1) << (SAMPLE_W - 1);

  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] v);
    mag_of = v[MAG_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Coefficients as magnitude and sign
  logic [COEF_W-1:0] b0_mag_r, a1_mag_r, a2_mag_r;
  logic              b0_neg_r, a1_neg_r, a2_neg_r;
  logic [COEF_W-1:0] cfg_mag;

  // Captured item
  logic signed [SAMPLE_W-1:0] x_r;
  logic [CHAN_W-1:0]          chan_r;
  logic [TS_W-1:0]            ts_r;
  logic                       fend_r;

  // History store
  logic [2*HISTORY_WIDTH-1:0] hist_mem [MAX_CHANNELS];
  logic [2*HISTORY_WIDTH-1:0] hist_q_r;
  logic [MAX_CHANNELS-1:0]    hist_vld_r;
  logic                       hist_vld_q_r;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;

  // Arithmetic
  logic signed [HISTORY_WIDTH-1:0] h1_r, h2_r;
  logic signed [SUM_W-1:0]         h1_s, h2_s, w_s;
  logic signed [SUM_W-1:0]         sum_r;
  logic [MAG_W-1:0]                mag1_r, mag2_r, magb_r;
  logic                            neg1_r, neg2_r, negb_r;
  logic [MUL_W-1:0]                mul_a, mul_b;
  logic [2*MUL_W-1:0]              prod_r;
  logic [PROD_W-1:0]               acc_r, acc_nxt;
  logic signed [W_ACC_W-1:0]       w_r, w_nxt, w_init, w_diff, ta;
  logic [YR_W-1:0]                 yr;
  logic [SAMPLE_W-1:0]             y_val;

  // Result register
  logic [TDATA_W-1:0] out_data_r;
  logic               out_last_r;
  logic               out_user_r;

  assign cfg_mag = cfg_data[COEF_W-1] ? (~cfg_data[COEF_W-1:0] + 1'b1) : cfg_data[COEF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_mag_r <= B0_RST;
      b0_neg_r <= 1'b0;
      a1_mag_r <= '0;
      a1_neg_r <= 1'b0;
      a2_mag_r <= '0;
      a2_neg_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B0: begin
          b0_mag_r <= cfg_mag;
          b0_neg_r <= cfg_data[COEF_W-1];
        end
        REG_A1: begin
          a1_mag_r <= cfg_mag;
          a1_neg_r <= cfg_data[COEF_W-1];
        end
        REG_A2: begin
          a2_mag_r <= cfg_mag;
          a2_neg_r <= cfg_data[COEF_W-1];
        end
        default: ;
      endcase
    end
  end

  // Capture item fields and read history at the accepting edge
  assign rd_addr = in_tdata[CHAN_LSB +: ADDR_W];
  assign wr_addr = chan_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r      <= in_tdata[SAMPLE_W-1:0];
      chan_r   <= in_tdata[CHAN_LSB +: CHAN_W];
      ts_r     <= in_tdata[TS_LSB +: TS_W];
      fend_r   <= in_tlast;
      hist_q_r <= hist_mem[rd_addr];
    end
    if (cmd.hist_wr) begin
      hist_mem[wr_addr] <= {h1_r, w_r[HISTORY_WIDTH-1:0]};
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r   <= '0;
      hist_vld_q_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        hist_vld_q_r <= hist_vld_r[rd_addr];
      end
      if (cmd.hist_wr) begin
        hist_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign h1_s   = {{(SUM_W-HISTORY_WIDTH){h1_r[HISTORY_WIDTH-1]}}, h1_r};
  assign h2_s   = {{(SUM_W-HISTORY_WIDTH){h2_r[HISTORY_WIDTH-1]}}, h2_r};
  assign w_s    = {{(SUM_W-HISTORY_WIDTH){w_r[HISTORY_WIDTH-1]}}, w_r[HISTORY_WIDTH-1:0]};
  assign w_init = {{(W_ACC_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r} <<< HIST_FRAC_BITS;
  assign ta     = acc_r[COEF_FRAC_BITS +: W_ACC_W];

  // Multiplier operand select: coefficient magnitude times one 32-bit slice
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_A1_LO: begin
        mul_a = a1_mag_r;
        mul_b = mag1_r[MUL_W-1:0];
      end
      MUL_A1_HI: begin
        mul_a = a1_mag_r;
        mul_b = MUL_W'(mag1_r[MAG_W-1:MUL_W]);
      end
      MUL_A2_LO: begin
        mul_a = a2_mag_r;
        mul_b = mag2_r[MUL_W-1:0];
      end
      MUL_A2_HI: begin
        mul_a = a2_mag_r;
        mul_b = MUL_W'(mag2_r[MAG_W-1:MUL_W]);
      end
      MUL_B_LO: begin
        mul_a = b0_mag_r;
        mul_b = magb_r[MUL_W-1:0];
      end
      MUL_B_HI: begin
        mul_a = b0_mag_r;
        mul_b = MUL_W'(magb_r[MAG_W-1:MUL_W]);
      end
      default: ;
    endcase
  end

  // Accumulate low slice plus rounding, then the high slice
  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      ACC_LOAD_A: acc_nxt = PROD_W'(prod_r) + RND_A;
      ACC_LOAD_B: acc_nxt = PROD_W'(prod_r) + RND_B;
      ACC_ADD_HI: acc_nxt = acc_r + {prod_r[PROD_W-MUL_W-1:0], {MUL_W{1'b0}}};
      default: ;
    endcase
  end

  // Subtract the signed feedback terms; clamp after the second
  always_comb begin
    w_diff = neg2_r ? (w_r + ta) : (w_r - ta);
    w_nxt  = w_r;
    if (cmd.fetch) begin
      w_nxt = w_init;
    end else begin
      case (cmd.w_op)
        W_APPLY1: w_nxt = neg1_r ? (w_r + ta) : (w_r - ta);
        W_APPLY2: begin
          if (w_diff > W_HMAX) begin
            w_nxt = W_HMAX;
          end else if (w_diff < W_HMIN) begin
            w_nxt = W_HMIN;
          end else begin
            w_nxt = w_diff;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      h1_r <= hist_vld_q_r ? hist_q_r[HISTORY_WIDTH-1:0] : '0;
      h2_r <= hist_vld_q_r ? hist_q_r[2*HISTORY_WIDTH-1:HISTORY_WIDTH] : '0;
    end
    if (cmd.mag_a) begin
      mag1_r <= mag_of(h1_s);
      neg1_r <= a1_neg_r ^ h1_r[HISTORY_WIDTH-1];
      mag2_r <= mag_of(h2_s);
      neg2_r <= a2_neg_r ^ h2_r[HISTORY_WIDTH-1];
    end
    if (cmd.sum_en) begin
      sum_r <= w_s + (h1_s <<< 1) + h2_s;
    end
    if (cmd.mag_b) begin
      magb_r <= mag_of(sum_r);
      negb_r <= b0_neg_r ^ sum_r[SUM_W-1];
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
  end

  // Round-shifted output magnitude, signed and saturated to the sample range
  assign yr = acc_r[OUT_SHIFT +: YR_W];

  always_comb begin
    if (!negb_r) begin
      y_val = (yr > Y_POS_LIM) ? {1'b0, {(SAMPLE_W-1){1'b1}}} : yr[SAMPLE_W-1:0];
    end else begin
      y_val = (yr > Y_NEG_LIM) ? {1'b1, {(SAMPLE_W-1){1'b0}}} : (~yr[SAMPLE_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {ts_r, chan_r, y_val};
      out_last_r <= fend_r;
      out_user_r <= cmd.out_block_last;
    end
  end

  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_user_r;
  assign stat.fend    = fend_r;

  a_hist_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_wr |-> (w_r <= W_HMAX && w_r >= W_HMIN))
    else $error("history write outside saturation range");

  a_hist_after_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_wr |-> $past(cmd.w_op == W_APPLY2))
    else $error("history written before final feedback step");

  // The accumulator either just finished the output product or has held it
  // while the result slot was busy.
  a_out_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $past(cmd.acc_op == ACC_ADD_HI || cmd.acc_op == ACC_HOLD))
    else $error("result loaded before output product complete");

endmodule

@@ rtl/bqdec_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bqdec_ctrl: sequencer, decimation and block counters
// Steps the datapath through the six partial products of one sample, decides
// whether the result is kept and owns the output valid flag.
// ============================================================================
module bqdec_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bqdec_pkg::CFG_W-1:0]     cfg_data,
  input  bqdec_pkg::dp_stat_t             stat,
  output bqdec_pkg::dp_cmd_t              cmd
);
  import bqdec_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] decim_r, blksz_r;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0] blkcnt_r, blkcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W:0]   ph_inc, blk_inc;
  logic             emit, ph_wrap, blk_wrap, out_free, advance;

  assign emit     = (phase_r == '0);
  assign ph_inc   = {1'b0, phase_r} + 1'b1;
  assign blk_inc  = {1'b0, blkcnt_r} + 1'b1;
  assign ph_wrap  = (ph_inc >= {1'b0, decim_r});
  assign blk_wrap = (blk_inc >= {1'b0, blksz_r});
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      blkcnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      blkcnt_r    <= blkcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r <= DECIM_RST;
      blksz_r <= BLOCK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DECIM: decim_r <= cfg_data[CNT_W-1:0];
        REG_BLOCK: blksz_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt          = state_r;
    advance            = 1'b0;
    cmd.capture        = 1'b0;
    cmd.fetch          = 1'b0;
    cmd.mag_a          = 1'b0;
    cmd.mul_sel        = MUL_NONE;
    cmd.acc_op         = ACC_HOLD;
    cmd.w_op           = W_HOLD;
    cmd.sum_en         = 1'b0;
    cmd.mag_b          = 1'b0;
    cmd.hist_wr        = 1'b0;
    cmd.out_load       = 1'b0;
    cmd.out_block_last = stat.fend && blk_wrap;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag_a = 1'b1;
        state_nxt = ST_A1_LO;
      end
      ST_A1_LO: begin
        cmd.mul_sel = MUL_A1_LO;
        state_nxt   = ST_A1_HI;
      end
      ST_A1_HI: begin
        cmd.mul_sel = MUL_A1_HI;
        cmd.acc_op  = ACC_LOAD_A;
        state_nxt   = ST_A2_LO;
      end
      ST_A2_LO: begin
        cmd.mul_sel = MUL_A2_LO;
        cmd.acc_op  = ACC_ADD_HI;
        state_nxt   = ST_A2_HI;
      end
      ST_A2_HI: begin
        cmd.mul_sel = MUL_A2_HI;
        cmd.acc_op  = ACC_LOAD_A;
        cmd.w_op    = W_APPLY1;
        state_nxt   = ST_A2_ACC;
      end
      ST_A2_ACC: begin
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = ST_W_FIN;
      end
      ST_W_FIN: begin
        cmd.w_op  = W_APPLY2;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en  = 1'b1;
        cmd.hist_wr = 1'b1;
        state_nxt   = ST_B_MAG;
      end
      ST_B_MAG: begin
        cmd.mag_b = 1'b1;
        state_nxt = ST_B_LO;
      end
      ST_B_LO: begin
        cmd.mul_sel = MUL_B_LO;
        state_nxt   = ST_B_HI;
      end
      ST_B_HI: begin
        cmd.mul_sel = MUL_B_HI;
        cmd.acc_op  = ACC_LOAD_B;
        state_nxt   = ST_B_ACC;
      end
      ST_B_ACC: begin
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        // Drop the sample off-phase; otherwise hold until the result slot frees
        if (!emit) begin
          advance   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          advance      = 1'b1;
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    blkcnt_nxt = blkcnt_r;
    if (advance && stat.fend) begin
      phase_nxt = ph_wrap ? '0 : ph_inc[CNT_W-1:0];
      if (emit) begin
        blkcnt_nxt = blk_wrap ? '0 : blk_inc[CNT_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_FETCH)
    else $error("accepted beat did not start processing");

  a_emit_on_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> phase_r == '0)
    else $error("result emitted off decimation phase");

  a_blk_only_at_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(blkcnt_r) |-> $past(state_r) == ST_OUT)
    else $error("block counter moved outside result step");

endmodule

@@ rtl/biquad_lowpass_decimator_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// biquad_lowpass_decimator_unit: multichannel low-pass biquad decimator
// Per-channel direct-form-II Butterworth-style biquad with decimation by
// frames and block-end marking.
// ============================================================================
// Usage:
//   in_*  : one beat per channel sample, channels of a frame in order, in_tlast
//           on the frame's last channel. tdata = {timestamp, channel, sample}.
//   out_* : one beat per kept sample (frames where the decimation phase is
//           zero). out_tlast marks the frame's last channel, out_tuser the
//           last beat of a block of block_size output frames.
//   cfg_* : register writes (0 decimation factor, 1 block size, 2 b0, 3 a1,
//           4 a2; Q2.30 coefficients); issue them only while the block is idle.
// Timing: a beat is accepted only in the idle state, once the last one is done.
//   The single 32x32 multiplier is used for six partial products in sequence
//   (two per coefficient), and the b0 product waits on the finished w. The
//   result lands in the output register and out_tvalid rises at the same edge.
// Stall: the output register holds a result while out_tready is low; the next
//   beat is still accepted and worked on, and its result waits in the last
//   step until the register frees.
// Reset: registers go to their defaults, phase and block count clear, and all
//   256 channel histories read as zero at once through per-entry valid flags.
// ============================================================================
module biquad_lowpass_decimator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bqdec_pkg::TDATA_W-1:0]   in_tdata,   // sample_value[23:0], channel[31:24],
                                                      // timestamp[79:32]
  input  logic                            in_tlast,   // frame_end
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bqdec_pkg::TDATA_W-1:0]   out_tdata,  // filtered_value[23:0],
                                                      // out_channel[31:24],
                                                      // out_timestamp[79:32]
  output logic                            out_tlast,  // frame_last
  output logic [0:0]                      out_tuser,  // block_last[0]
  // Register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqdec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bqdec_pkg::CFG_W-1:0]     cfg_data
);
  import bqdec_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: owns the handshakes, decimation phase and block count
  bqdec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: coefficients, history memory, multiplier and result register
  bqdec_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

@@ tb/sv/biquad_lowpass_decimator_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// biquad_lowpass_decimator_unit_tb: self-checking bench for the biquad decimator
// Streams channel frames through the unit under several register settings,
// recomputes every kept sample with a bit-exact fixed-point filter of its own,
// and checks each output beat field by field in arrival order.
// ============================================================================
module biquad_lowpass_decimator_unit_tb;
  import bqdec_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Lowpass near a tenth of the sample rate, Q2.30
  localparam logic [31:0] LP_B0 = 32'sd72434000;
  localparam logic [31:0] LP_A1 = -32'sd1227202000;
  localparam logic [31:0] LP_A2 = 32'sd443241000;
  localparam logic [31:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COEF_MIN = 32'h8000_0000;

  localparam logic signed [127:0] S64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] S64_MIN = -S64_MAX - 1;
  localparam longint HIST_MAX = (64'sd1 <<< (HISTORY_WIDTH - 1)) - 1;
  localparam longint HIST_MIN = -HIST_MAX - 1;
  localparam longint OUT_MAX  = 64'sd8388607;
  localparam longint OUT_MIN  = -64'sd8388608;

  // Cycles to let pass after the last result before touching registers or
  // ending: well above the time one beat spends inside the unit.
  localparam int QUIET_CYCLES = 40;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   chan;
    logic                fend;
    logic [TS_W-1:0]     ts;
  } sample_beat_t;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    logic [CHAN_W-1:0]   chan;
    logic [TS_W-1:0]     ts;
    logic                flast;
    logic                blast;
  } filtered_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata = '0;   // sample_value[23:0], channel[31:24], timestamp[79:32]
  logic                 in_tlast = 1'b0; // frame_end

  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;       // filtered_value[23:0], out_channel[31:24],
                                         // out_timestamp[79:32]
  logic                 out_tlast;       // frame_last
  logic [0:0]           out_tuser;       // block_last[0]

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  biquad_lowpass_decimator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case a beat is never accepted or a result never shows up.
  initial begin
    #2_000_000;
    $display("biquad_lowpass_decimator_unit_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Filter copy: registers, per-channel history, frame phase and block count
  // --------------------------------------------------------------------------
  int unsigned decim_factor = DECIM_RST;
  int unsigned block_frames = BLOCK_RST;
  longint      gain_b0 = 64'sd1 <<< COEF_FRAC_BITS;
  longint      fb_a1 = 0;
  longint      fb_a2 = 0;
  longint      hist_one [MAX_CHANNELS];
  longint      hist_two [MAX_CHANNELS];
  int unsigned frame_phase = 0;
  int unsigned frames_in_block = 0;

  sample_beat_t   pending_beats[$];
  filtered_beat_t expected_results[$];
  sample_beat_t   next_beat;
  filtered_beat_t want_beat;

  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  int unsigned block_marks = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_pct = 27;

  logic in_hs = 1'b0;
  logic cfg_hs = 1'b0;

  initial begin
    foreach (hist_one[i]) begin
      hist_one[i] = 0;
      hist_two[i] = 0;
    end
  end

  function automatic longint sat64(logic signed [127:0] v);
    if (v > S64_MAX) return S64_MAX[63:0];
    if (v < S64_MIN) return S64_MIN[63:0];
    return v[63:0];
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [127:0] s;
    s = a;
    return sat64(s + b);
  endfunction

  function automatic longint sat_diff(longint a, longint b);
    logic signed [127:0] s;
    s = a;
    return sat64(s - b);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Coefficient times value, shifted right by rshift with rounding half away
  // from zero, magnitude held to the 64-bit signed range.
  function automatic longint scaled_product(longint coef, longint v, int rshift);
    logic signed [127:0] cw, vw;
    logic [127:0] cm, vm, mag;
    logic neg;
    cw = coef;
    vw = v;
    neg = (coef < 0) != (v < 0);
    cm = (cw < 0) ? -cw : cw;
    vm = (vw < 0) ? -vw : vw;
    mag = (cm * vm + (128'd1 << (rshift - 1))) >> rshift;
    if (mag > 128'h7FFF_FFFF_FFFF_FFFF) mag = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  // Run one channel sample through its biquad, advance the history, and queue
  // the output beat when the frame phase says this frame is kept.
  function automatic void filter_sample(logic [SAMPLE_W-1:0] xraw, logic [CHAN_W-1:0] ch,
                                        logic fend, logic [TS_W-1:0] ts);
    longint x, h1, h2, w, total, y;
    int unsigned nxt;
    filtered_beat_t res;
    x = $signed(xraw);
    h1 = hist_one[ch];
    h2 = hist_two[ch];
    w = x * (64'sd1 <<< HIST_FRAC_BITS);
    w = sat_diff(w, scaled_product(fb_a1, h1, COEF_FRAC_BITS));
    w = sat_diff(w, scaled_product(fb_a2, h2, COEF_FRAC_BITS));
    w = clip(w, HIST_MIN, HIST_MAX);
    total = sat_sum(sat_sum(w, h1), sat_sum(h1, h2));
    y = clip(scaled_product(gain_b0, total, OUT_SHIFT), OUT_MIN, OUT_MAX);
    hist_two[ch] = h1;
    hist_one[ch] = w;
    if (frame_phase == 0) begin
      res.blast = 1'b0;
      if (fend) begin
        // a block size of zero or one already passed closes the block now
        nxt = frames_in_block + 1;
        if (nxt >= block_frames) begin
          res.blast = 1'b1;
          nxt = 0;
        end
        frames_in_block = nxt & 16'hFFFF;
      end
      res.value = y[SAMPLE_W-1:0];
      res.chan  = ch;
      res.ts    = ts;
      res.flast = fend;
      expected_results.push_back(res);
    end
    if (fend) begin
      // factor zero wraps at once, like factor one
      nxt = frame_phase + 1;
      frame_phase = (nxt >= decim_factor) ? 0 : (nxt & 16'hFFFF);
    end
  endfunction

  task automatic report_mismatch(string field, logic [TS_W-1:0] want, logic [TS_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d, %s: expected %0h, got %0h",
               results_seen, field, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_hs  <= rst_n && in_tvalid && in_tready;
    cfg_hs <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_reg_t'(cfg_index))
          REG_DECIM: decim_factor = cfg_data[CNT_W-1:0];
          REG_BLOCK: block_frames = cfg_data[CNT_W-1:0];
          REG_B0:    gain_b0 = $signed(cfg_data);
          REG_A1:    fb_a1 = $signed(cfg_data);
          REG_A2:    fb_a2 = $signed(cfg_data);
          default: ;  // no register behind this index
        endcase
      end
      if (in_tvalid && in_tready) begin
        filter_sample(in_tdata[SAMPLE_W-1:0], in_tdata[CHAN_LSB +: CHAN_W], in_tlast,
                      in_tdata[TS_LSB +: TS_W]);
        beats_taken++;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser[0]) block_marks++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, out_tdata[TS_LSB +: TS_W]);
        end else begin
          want_beat = expected_results.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want_beat.value)
            report_mismatch("filtered_value", want_beat.value, out_tdata[SAMPLE_W-1:0]);
          if (out_tdata[CHAN_LSB +: CHAN_W] !== want_beat.chan)
            report_mismatch("out_channel", want_beat.chan, out_tdata[CHAN_LSB +: CHAN_W]);
          if (out_tdata[TS_LSB +: TS_W] !== want_beat.ts)
            report_mismatch("out_timestamp", want_beat.ts, out_tdata[TS_LSB +: TS_W]);
          if (out_tlast !== want_beat.flast)
            report_mismatch("frame_last", want_beat.flast, out_tlast);
          if (out_tuser[0] !== want_beat.blast)
            report_mismatch("block_last", want_beat.blast, out_tuser[0]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs at the falling edge only
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    // hold the current beat until it is taken, then advance or idle
    if (rst_n && (!in_tvalid || in_hs)) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_beat = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {next_beat.ts, next_beat.chan, next_beat.sample};
        in_tlast  <= next_beat.fend;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_beat(logic [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] ch, logic fend,
                           logic [TS_W-1:0] ts);
    sample_beat_t b;
    b.sample = s;
    b.chan   = ch;
    b.fend   = fend;
    b.ts     = ts;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 24'h7FFFFF;
    if (r < 20) return 24'h800000;
    if (r < 45) return SAMPLE_W'($urandom_range(2047)) - 24'd1024;
    return SAMPLE_W'($urandom());
  endfunction

  // Mostly well-formed frames (channels from 0 up, last one flagged, one
  // timestamp per frame); the rest stray beats on any channel.
  task automatic push_frames(int n);
    int left, nch, k;
    logic [TS_W-1:0] ts;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 12) begin
        push_beat(pick_sample(), CHAN_W'($urandom()), 1'($urandom()), TS_W'({$urandom(), $urandom()}));
        left--;
      end else begin
        nch = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 4);
        ts = TS_W'({$urandom(), $urandom()});
        for (k = 0; k < nch; k++)
          push_beat(pick_sample(), CHAN_W'(k), k == nch - 1, ts);
        left -= nch;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_hs) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every beat is taken and every result is back, then
  // let the unit finish any beat that produces no result.
  task automatic settle();
    @(negedge clk);
    while (beats_taken != beats_queued || expected_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_all(logic [CFG_W-1:0] factor, logic [CFG_W-1:0] blk,
                           logic [CFG_W-1:0] b0, logic [CFG_W-1:0] a1, logic [CFG_W-1:0] a2);
    write_reg(REG_DECIM, factor);
    write_reg(REG_BLOCK, blk);
    write_reg(REG_B0, b0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: every frame kept, b0 of one, no feedback, blocks of ten.
    // Full-scale samples push the sum past the 24-bit output range.
    push_beat(24'h7FFFFF, 8'd0, 1'b0, 48'h0);
    push_beat(24'h800000, 8'd1, 1'b0, 48'h0);
    push_beat(24'h000000, 8'd2, 1'b0, 48'h0);
    push_beat(24'hFFFFFF, 8'd3, 1'b1, 48'h0);
    push_beat(24'h800000, 8'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
    push_beat(24'h7FFFFF, 8'd1, 1'b0, 48'hFFFF_FFFF_FFFF);
    push_beat(24'h000001, 8'd2, 1'b0, 48'hFFFF_FFFF_FFFF);
    push_beat(24'h7FFFFF, 8'd3, 1'b1, 48'hFFFF_FFFF_FFFF);
    // channels out of order and a frame that never flags its end in order
    push_beat(24'h123456, 8'd7, 1'b0, 48'hAAAA_5555_AAAA);
    push_beat(24'h800000, 8'd2, 1'b1, 48'h5555_AAAA_5555);
    // single-channel frames through the end of the first block and into the second
    push_beat(24'h7FFFFF, 8'd255, 1'b1, 48'h0000_0000_0001);
    push_beat(24'h7FFFFF, 8'd255, 1'b1, 48'h8000_0000_0000);
    push_beat(24'h800000, 8'd128, 1'b1, 48'h0000_0001_0000);
    push_beat(24'h000000, 8'd0, 1'b1, 48'h0000_0000_0002);
    push_beat(24'h400000, 8'd85, 1'b1, 48'h0000_0000_0003);
    push_beat(24'hC00000, 8'd170, 1'b1, 48'h0000_0000_0004);
    push_beat(24'h000100, 8'd0, 1'b1, 48'h0000_0000_0005);
    push_beat(24'hFFFF00, 8'd0, 1'b1, 48'h0000_0000_0006);
    push_beat(24'h7FFFFF, 8'd1, 1'b1, 48'h0000_0000_0007);
    settle();

    // Lowpass, every frame kept, blocks of five; the spare index is ignored.
    write_reg(REG_SPARE, $urandom());
    write_all(32'd1, 32'd5, LP_B0, LP_A1, LP_A2);
    push_frames(320);
    settle();
    // park the frame count at four so the next block size lies below it
    while (frames_in_block != 4) begin
      push_beat(pick_sample(), 8'd0, 1'b1, TS_W'({$urandom(), $urandom()}));
      settle();
    end

    // Keep one frame in three, block of two; junk in the unused upper bits.
    // Both sides run without a single idle cycle here.
    idle_pct = 0;
    write_reg(REG_DECIM, {16'($urandom()), 16'd3});
    write_reg(REG_BLOCK, {16'($urandom()), 16'd2});
    push_frames(320);
    settle();
    idle_pct = 27;

    // Factor and block size zero, coefficients at their extremes.
    write_all(32'd0, 32'd0, COEF_MAX, COEF_MIN, COEF_MAX);
    push_frames(150);
    settle();

    // Largest factor and block size, opposite coefficient extremes.
    write_all(32'd65535, 32'd65535, COEF_MIN, COEF_MAX, COEF_MIN);
    push_frames(50);
    settle();

    // Every other frame, one frame per block, random coefficients.
    write_all(32'd2, 32'd1, $urandom(), $urandom(), $urandom());
    push_frames(130);
    settle();
    push_frames(130);
    settle();

    // Back to the lowpass, one frame in four, blocks of five.
    write_all(32'd4, 32'd5, LP_B0, LP_A1, LP_A2);
    push_frames(250);
    settle();

    $display("run covered %0d input beats and %0d register writes over seven settings,",
             beats_taken, reg_writes);
    $display("  %0d filtered results with %0d block ends, %0d mismatches",
             results_seen, block_marks, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("biquad_lowpass_decimator_unit_tb: done, clean");
    end else begin
      $display("biquad_lowpass_decimator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bqdec_pkg.sv
rtl/bqdec_datapath.sv
rtl/bqdec_ctrl.sv
rtl/biquad_lowpass_decimator_unit.sv
tb/sv/biquad_lowpass_decimator_unit_tb.sv
